// ===== hw/rtl/qvr_pkg.sv =====
// Shared types and constants for the quaternion vector rotator.
package qvr_pkg;

	localparam int VEC_W     = 32;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_W     = 32;
	localparam int TOL_W     = 30;
	localparam int NUM_COEF  = 9;
	localparam int LAT_W     = 2;

	localparam logic [TOL_W-1:0] TOL_RESET = 30'd21;
	// settle count, loaded on reset and on every register write
	localparam logic [LAT_W-1:0] CFG_LAT   = 2'd3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_QUAT_W   = 3'd0,
		REG_QUAT_I   = 3'd1,
		REG_QUAT_J   = 3'd2,
		REG_QUAT_K   = 3'd3,
		REG_NORM_TOL = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic unit;   // quaternion norm within tolerance
		logic ready;  // coefficients settled
	} coef_stat_t;

endpackage

// ===== hw/rtl/qvr_if.sv =====
// Valid/ready channel interfaces for input vectors and rotated results.
interface qvr_vec_if;
	logic                                valid;
	logic                                ready;
	logic signed [qvr_pkg::VEC_W-1:0]    vec_x;
	logic signed [qvr_pkg::VEC_W-1:0]    vec_y;
	logic signed [qvr_pkg::VEC_W-1:0]    vec_z;

	modport source (output valid, output vec_x, output vec_y, output vec_z, input ready);
	modport sink (input valid, input vec_x, input vec_y, input vec_z, output ready);
endinterface

interface qvr_rot_if;
	logic                                valid;
	logic                                ready;
	logic signed [qvr_pkg::VEC_W-1:0]    rot_x;
	logic signed [qvr_pkg::VEC_W-1:0]    rot_y;
	logic signed [qvr_pkg::VEC_W-1:0]    rot_z;
	logic                                not_unit;

	modport source (output valid, output rot_x, output rot_y, output rot_z,
		output not_unit, input ready);
	modport sink (input valid, input rot_x, input rot_y, input rot_z,
		input not_unit, output ready);
endinterface

// ===== hw/rtl/quaternion_vector_rotate.sv =====
// Top level: pipelined rotation of Q16.16 vectors by a configured quaternion.
//
// Usage:
//   vec_in  (valid/ready sink) takes one x/y/z word per cycle while its ready is high.
//   rot_out (valid/ready source) gives rot_x/rot_y/rot_z and not_unit.
//   cfg_we/cfg_idx/cfg_data write the quaternion (Q2.30 by default) and the
//   norm tolerance; write only while no word is in flight.
// A word accepted on vec_in passes the product, row-sum and output registers to rot_out.
// Throughput: one word per cycle when not stalled. The rate is set by the three-stage
//   datapath (nine multipliers, row adders, round/saturate), one word per stage.
// After reset and after every register write, vec_in.ready stays low while the
//   coefficient pipeline (squares/cross products, sums, rounding and norm
//   compare) settles on the new quaternion.
// Stalls: each stage holds its word when the next one is full and blocked;
//   bubbles fill up, so input is taken while a finished word waits at the
//   output register. Nothing is dropped or repeated.
// Reset (arst_n low, async) empties the pipeline and loads the identity
//   quaternion with a tolerance of 21 LSBs.
module quaternion_vector_rotate #(
	parameter int QUAT_FRAC_BITS = 30
) (
	input  logic                          clk,
	input  logic                          arst_n,
	qvr_vec_if.sink                       vec_in,
	qvr_rot_if.source                     rot_out,
	input  logic                          cfg_we,
	input  logic [qvr_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [qvr_pkg::CFG_W-1:0]     cfg_data
);

	localparam int CW = QUAT_FRAC_BITS + 3;           // coefficient width
	localparam int PW = CW + qvr_pkg::VEC_W;          // product width
	localparam int SW = PW + 2;                       // row sum width
	localparam logic signed [SW-1:0] HALF   = SW'(1) <<< (QUAT_FRAC_BITS - 1);
	localparam logic signed [SW-1:0] SAT_HI = (SW'(1) <<< 31) - SW'(1);
	localparam logic signed [SW-1:0] SAT_LO = -(SW'(1) <<< 31);

	logic signed [CW-1:0] coef [qvr_pkg::NUM_COEF];
	qvr_pkg::coef_stat_t  stat;

	logic signed [qvr_pkg::VEC_W-1:0] vin [3];

	// handshake
	logic rdy_s1, rdy_s2, rdy_s3, acc;
	logic v_s1, v_s2, v_s3;

	// stage 1: products
	logic signed [PW-1:0]              prod_s1 [qvr_pkg::NUM_COEF];
	logic signed [qvr_pkg::VEC_W-1:0]  vec_s1 [3];
	logic                              unit_s1;

	// stage 2: row sums with the rounding half added
	logic signed [SW-1:0]              sum_s2 [3];
	logic signed [qvr_pkg::VEC_W-1:0]  vec_s2 [3];
	logic                              unit_s2;

	// stage 3: output register
	logic signed [qvr_pkg::VEC_W-1:0]  rot_s3 [3];
	logic                              not_unit_s3;

	logic signed [SW-1:0]              shf [3];
	logic signed [qvr_pkg::VEC_W-1:0]  sat [3];

	qvr_coef #(
		.QUAT_FRAC_BITS (QUAT_FRAC_BITS)
	) u_coef (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.coef     (coef),
		.stat     (stat)
	);

	assign vin[0] = vec_in.vec_x;
	assign vin[1] = vec_in.vec_y;
	assign vin[2] = vec_in.vec_z;

	assign rdy_s3       = !v_s3 || rot_out.ready;
	assign rdy_s2       = !v_s2 || rdy_s3;
	assign rdy_s1       = !v_s1 || rdy_s2;
	assign vec_in.ready = rdy_s1 && stat.ready;
	assign acc          = vec_in.valid && vec_in.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= acc;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
		end
	end

	// floor((sum + half) / 2^F), then clamp to 32 bits
	always_comb begin
		for (int r = 0; r < 3; r++) begin
			shf[r] = sum_s2[r] >>> QUAT_FRAC_BITS;
			if (shf[r] > SAT_HI) begin
				sat[r] = SAT_HI[qvr_pkg::VEC_W-1:0];
			end else if (shf[r] < SAT_LO) begin
				sat[r] = SAT_LO[qvr_pkg::VEC_W-1:0];
			end else begin
				sat[r] = shf[r][qvr_pkg::VEC_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					prod_s1[r*3+c] <= coef[r*3+c] * vin[c];
				end
			end
			vec_s1  <= vin;
			unit_s1 <= stat.unit;
		end
		if (rdy_s2 && v_s1) begin
			for (int r = 0; r < 3; r++) begin
				sum_s2[r] <= SW'(prod_s1[r*3]) + SW'(prod_s1[r*3+1])
					+ SW'(prod_s1[r*3+2]) + HALF;
			end
			vec_s2  <= vec_s1;
			unit_s2 <= unit_s1;
		end
		if (rdy_s3 && v_s2) begin
			// off-norm quaternion: pass the vector through
			for (int r = 0; r < 3; r++) begin
				rot_s3[r] <= unit_s2 ? sat[r] : vec_s2[r];
			end
			not_unit_s3 <= !unit_s2;
		end
	end

	assign rot_out.valid    = v_s3;
	assign rot_out.rot_x    = rot_s3[0];
	assign rot_out.rot_y    = rot_s3[1];
	assign rot_out.rot_z    = rot_s3[2];
	assign rot_out.not_unit = not_unit_s3;

`ifndef SYNTHESIS
	// no word may enter on stale coefficients right after a register write
	a_cfg_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> !vec_in.ready)
		else $error("word accepted while coefficients settle");

	// a word leaving stage 2 into a free output register must show up
	a_s2_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && rdy_s3 |=> v_s3)
		else $error("word lost between stage 2 and output");

	// a blocked stage 2 keeps its word
	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && !rdy_s3 |=> v_s2 && $stable(sum_s2[0]) && $stable(unit_s2))
		else $error("stage 2 word changed while stalled");
`endif

endmodule

// ===== hw/rtl/qvr_coef.sv =====
// Configuration registers and three-stage rotation matrix / norm check pipeline.
module qvr_coef #(
	parameter int QUAT_FRAC_BITS = 30
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_we,
	input  logic [qvr_pkg::CFG_IDX_W-1:0]          cfg_idx,
	input  logic [qvr_pkg::CFG_W-1:0]              cfg_data,
	output logic signed [QUAT_FRAC_BITS+2:0]       coef [qvr_pkg::NUM_COEF],
	output qvr_pkg::coef_stat_t                    stat
);

	localparam int CW = QUAT_FRAC_BITS + 3;
	localparam int RW = 66;
	localparam logic signed [RW-1:0] ONE  = RW'(1) <<< (2 * QUAT_FRAC_BITS);
	localparam logic signed [RW-1:0] HALF = RW'(1) <<< (QUAT_FRAC_BITS - 1);
	localparam logic [31:0] W_RESET = 32'(1) << QUAT_FRAC_BITS;

	logic signed [31:0]              quat_w_q, quat_i_q, quat_j_q, quat_k_q;
	logic [qvr_pkg::TOL_W-1:0]       tol_q;
	logic [qvr_pkg::LAT_W-1:0]       busy_cnt_q;

	logic signed [63:0] ww_s1, ii_s1, jj_s1, kk_s1;
	logic signed [63:0] ij_s1, wk_s1, ik_s1, wj_s1, jk_s1, wi_s1;

	logic signed [RW-1:0] raw_s2 [qvr_pkg::NUM_COEF];
	logic signed [RW-1:0] norm_s2, hi_lim_s2, lo_lim_s2;

	logic signed [CW-1:0] coef_s3 [qvr_pkg::NUM_COEF];
	logic                 unit_s3;

	logic signed [RW-1:0] rnd [qvr_pkg::NUM_COEF];
	logic signed [RW-1:0] lim;

	// registers and settle counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quat_w_q   <= W_RESET;
			quat_i_q   <= '0;
			quat_j_q   <= '0;
			quat_k_q   <= '0;
			tol_q      <= qvr_pkg::TOL_RESET;
			busy_cnt_q <= qvr_pkg::CFG_LAT;
		end else begin
			if (cfg_we) begin
				case (qvr_pkg::cfg_reg_t'(cfg_idx))
					qvr_pkg::REG_QUAT_W:   quat_w_q <= cfg_data;
					qvr_pkg::REG_QUAT_I:   quat_i_q <= cfg_data;
					qvr_pkg::REG_QUAT_J:   quat_j_q <= cfg_data;
					qvr_pkg::REG_QUAT_K:   quat_k_q <= cfg_data;
					qvr_pkg::REG_NORM_TOL: tol_q    <= cfg_data[qvr_pkg::TOL_W-1:0];
					default: ;
				endcase
				busy_cnt_q <= qvr_pkg::CFG_LAT;
			end else if (busy_cnt_q != '0) begin
				busy_cnt_q <= busy_cnt_q - 1'b1;
			end
		end
	end

	assign lim = RW'(tol_q) <<< QUAT_FRAC_BITS;

	always_comb begin
		for (int n = 0; n < qvr_pkg::NUM_COEF; n++) begin
			rnd[n] = (raw_s2[n] + HALF) >>> QUAT_FRAC_BITS;
		end
	end

	// free-running: products, sums, then rounding and norm compare
	always_ff @(posedge clk) begin
		ww_s1 <= quat_w_q * quat_w_q;
		ii_s1 <= quat_i_q * quat_i_q;
		jj_s1 <= quat_j_q * quat_j_q;
		kk_s1 <= quat_k_q * quat_k_q;
		ij_s1 <= quat_i_q * quat_j_q;
		wk_s1 <= quat_w_q * quat_k_q;
		ik_s1 <= quat_i_q * quat_k_q;
		wj_s1 <= quat_w_q * quat_j_q;
		jk_s1 <= quat_j_q * quat_k_q;
		wi_s1 <= quat_w_q * quat_i_q;

		raw_s2[0] <= RW'(ww_s1) + RW'(ii_s1) - RW'(jj_s1) - RW'(kk_s1);
		raw_s2[1] <= (RW'(ij_s1) - RW'(wk_s1)) <<< 1;
		raw_s2[2] <= (RW'(ik_s1) + RW'(wj_s1)) <<< 1;
		raw_s2[3] <= (RW'(ij_s1) + RW'(wk_s1)) <<< 1;
		raw_s2[4] <= RW'(ww_s1) - RW'(ii_s1) + RW'(jj_s1) - RW'(kk_s1);
		raw_s2[5] <= (RW'(jk_s1) - RW'(wi_s1)) <<< 1;
		raw_s2[6] <= (RW'(ik_s1) - RW'(wj_s1)) <<< 1;
		raw_s2[7] <= (RW'(jk_s1) + RW'(wi_s1)) <<< 1;
		raw_s2[8] <= RW'(ww_s1) - RW'(ii_s1) - RW'(jj_s1) + RW'(kk_s1);
		norm_s2   <= RW'(ww_s1) + RW'(ii_s1) + RW'(jj_s1) + RW'(kk_s1);
		hi_lim_s2 <= ONE + lim;
		lo_lim_s2 <= ONE - lim;

		for (int n = 0; n < qvr_pkg::NUM_COEF; n++) begin
			coef_s3[n] <= rnd[n][CW-1:0];
		end
		unit_s3 <= (norm_s2 <= hi_lim_s2) && (norm_s2 >= lo_lim_s2);
	end

	assign coef       = coef_s3;
	assign stat.unit  = unit_s3;
	assign stat.ready = (busy_cnt_q == '0);

endmodule

// ===== test/qvr_tb_pkg.sv =====
`timescale 1ns / 1ps
// Word types and the rotation scoreboard class for the quaternion rotator testbench.
package qvr_tb_pkg;
	import qvr_pkg::*;

	localparam int QUAT_FRAC = 30;

	// indexes past the last register: writes there must change nothing
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

	typedef logic signed [VEC_W-1:0] coord_t;
	typedef logic signed [127:0]     wide_t;

	localparam coord_t QUAT_ONE = coord_t'(1) <<< QUAT_FRAC;

	typedef struct packed {
		coord_t x;
		coord_t y;
		coord_t z;
		logic   not_unit;
	} rot_word_t;

	class rotation_board;
		coord_t           quat[4];
		logic [TOL_W-1:0] tol;
		rot_word_t        rotations_due[$];
		int               mismatches;

		function new();
			quat[0] = QUAT_ONE;
			quat[1] = '0;
			quat[2] = '0;
			quat[3] = '0;
			tol = TOL_RESET;
			mismatches = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
			case (idx)
				REG_QUAT_W:   quat[0] = data;
				REG_QUAT_I:   quat[1] = data;
				REG_QUAT_J:   quat[2] = data;
				REG_QUAT_K:   quat[3] = data;
				REG_NORM_TOL: tol = data[TOL_W-1:0];
				default: ;
			endcase
		endfunction

		// floor((a + half LSB) / 2^F): round half toward plus infinity
		static function wide_t round_q(wide_t a);
			return (a + (wide_t'(1) <<< (QUAT_FRAC - 1))) >>> QUAT_FRAC;
		endfunction

		static function coord_t clamp32(wide_t a);
			if (a > wide_t'(32'sh7fffffff))
				return 32'sh7fffffff;
			if (a < wide_t'(32'sh80000000))
				return 32'sh80000000;
			return a[VEC_W-1:0];
		endfunction

		// works out the rotated word for an accepted vector and queues it
		function void add_rotation(coord_t vx, coord_t vy, coord_t vz);
			wide_t     w, i, j, k, dev, acc;
			wide_t     c[9];
			wide_t     v[3];
			coord_t    row[3];
			rot_word_t r;
			int        n;
			w = quat[0];
			i = quat[1];
			j = quat[2];
			k = quat[3];
			v[0] = vx;
			v[1] = vy;
			v[2] = vz;
			// exact squared norm against one, both in 2F fraction bits
			dev = w*w + i*i + j*j + k*k - (wide_t'(1) <<< (2*QUAT_FRAC));
			if (dev < 0)
				dev = -dev;
			if (dev > (wide_t'(tol) <<< QUAT_FRAC)) begin
				r = '{vx, vy, vz, 1'b1};
			end else begin
				c[0] = round_q(w*w + i*i - j*j - k*k);
				c[1] = round_q(2*(i*j - w*k));
				c[2] = round_q(2*(i*k + w*j));
				c[3] = round_q(2*(i*j + w*k));
				c[4] = round_q(w*w - i*i + j*j - k*k);
				c[5] = round_q(2*(j*k - w*i));
				c[6] = round_q(2*(i*k - w*j));
				c[7] = round_q(2*(j*k + w*i));
				c[8] = round_q(w*w - i*i - j*j + k*k);
				for (n = 0; n < 3; n++) begin
					acc = c[3*n]*v[0] + c[3*n+1]*v[1] + c[3*n+2]*v[2];
					row[n] = clamp32(round_q(acc));
				end
				r = '{row[0], row[1], row[2], 1'b0};
			end
			rotations_due.push_back(r);
		endfunction

		function void check_rotation(rot_word_t got);
			rot_word_t want;
			if (rotations_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected word: x=%0d y=%0d z=%0d not_unit=%0b",
						got.x, got.y, got.z, got.not_unit);
				return;
			end
			want = rotations_due.pop_front();
			if (got.x !== want.x || got.y !== want.y || got.z !== want.z ||
					got.not_unit !== want.not_unit) begin
				mismatches++;
				if (mismatches <= 10)
					$display("bad word: want x=%0d y=%0d z=%0d nu=%0b, got x=%0d y=%0d z=%0d nu=%0b",
						want.x, want.y, want.z, want.not_unit,
						got.x, got.y, got.z, got.not_unit);
			end
		endfunction
	endclass

endpackage

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// Top of the quaternion rotator testbench: clock, reset, stimulus, checks and watchdog.
module tb;
	import qvr_pkg::*;
	import qvr_tb_pkg::*;

	localparam int N_ITEMS      = 1600;
	localparam int CALM_ITEMS   = 150;  // tail of the run with no idling at all
	localparam int IDLE_MAX     = 18;
	localparam int STALL_LIMIT  = 2000; // cycles with no handshake and no write
	localparam int DRAIN_CYCLES = 8;    // covers the 3-stage datapath with margin

	localparam coord_t MAXV      = 32'sh7fffffff;
	localparam coord_t MINV      = 32'sh80000000;
	localparam coord_t ROOT_HALF = 32'sd759250125;   // cos(45 deg), Q2.30
	localparam coord_t ROOT_TWO  = 32'sd1518500249;  // just under sqrt(2): norm^2 near 2
	localparam logic [CFG_W-1:0] TOL_MAX = {{(CFG_W-TOL_W){1'b0}}, {TOL_W{1'b1}}};
	localparam logic [CFG_W-1:0] TOL_DFLT = {{(CFG_W-TOL_W){1'b0}}, TOL_RESET};

	logic                 clk      = 1'b0;
	logic                 arst_n   = 1'b0;
	logic                 cfg_we   = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_idx  = '0;
	logic [CFG_W-1:0]     cfg_data = '0;

	qvr_vec_if vec_in();
	qvr_rot_if rot_out();

	rotation_board board;

	int src_idle_pct = 0;
	int snk_idle_pct = 0;
	int sent         = 0;
	int quiet_cycles = 0;
	int stall_left   = 0;
	bit calm         = 1'b0;

	quaternion_vector_rotate #(
		.QUAT_FRAC_BITS(QUAT_FRAC)
	) i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.vec_in  (vec_in),
		.rot_out (rot_out),
		.cfg_we  (cfg_we),
		.cfg_idx (cfg_idx),
		.cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	// Result side: check every accepted word, then decide ready for the next
	// cycle. Stalls come in random bursts bounded by IDLE_MAX.
	always @(posedge clk) begin : result_side
		rot_word_t seen;
		logic      go;
		if (arst_n && rot_out.valid && rot_out.ready) begin
			seen.x = rot_out.rot_x;
			seen.y = rot_out.rot_y;
			seen.z = rot_out.rot_z;
			seen.not_unit = rot_out.not_unit;
			board.check_rotation(seen);
		end
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			go = 1'b0;
		end else if (!calm && $urandom_range(99) < snk_idle_pct) begin
			stall_left <= $urandom_range(IDLE_MAX - 1, 0);
			go = 1'b0;
		end else begin
			go = 1'b1;
		end
		rot_out.ready <= go;
	end

	// Watchdog: any handshake or register write restarts the count.
	always @(posedge clk) begin
		if (!arst_n || (vec_in.valid && vec_in.ready) || (rot_out.valid && rot_out.ready) ||
				cfg_we) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("tb NOT OK");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// one register write; the model follows at the edge that takes it
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= data;
		@(posedge clk);
		board.set_reg(idx, data);
	endtask

	// New quaternion and tolerance. Only once every queued word has come out,
	// plus a DRAIN_CYCLES wait so the output stage is surely empty.
	task automatic load_quat(input coord_t w, input coord_t i, input coord_t j,
			input coord_t k, input logic [CFG_W-1:0] tol, input bit spare);
		vec_in.valid <= 1'b0;
		while (board.rotations_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		// a write past the last register index goes nowhere
		if (spare)
			write_reg(CFG_IDX_W'($urandom_range(REG_SPARE_HI, REG_SPARE_LO)), $urandom());
		write_reg(REG_QUAT_W, w);
		write_reg(REG_QUAT_I, i);
		write_reg(REG_QUAT_J, j);
		write_reg(REG_QUAT_K, k);
		write_reg(REG_NORM_TOL, tol);
		cfg_we <= 1'b0;
	endtask

	// Offer one vector; returns at the edge that accepts it. Valid stays high
	// on return, so back-to-back words follow with no gap in valid.
	task automatic send_vec(input coord_t x, input coord_t y, input coord_t z);
		if (!calm && $urandom_range(99) < src_idle_pct) begin
			vec_in.valid <= 1'b0;
			repeat ($urandom_range(IDLE_MAX, 1)) @(posedge clk);
		end
		vec_in.valid <= 1'b1;
		vec_in.vec_x <= x;
		vec_in.vec_y <= y;
		vec_in.vec_z <= z;
		@(posedge clk);
		while (!vec_in.ready)
			@(posedge clk);
		board.add_rotation(x, y, z);
		sent++;
		if (sent >= N_ITEMS - CALM_ITEMS)
			calm = 1'b1;
	endtask

	// a mix of full-range words and small, medium and extreme values
	function automatic coord_t pick_coord();
		int unsigned roll;
		roll = $urandom_range(99);
		if (roll < 40)
			return $urandom();
		if (roll < 65)
			return coord_t'($urandom_range(13107200)) - 32'sd6553600;
		if (roll < 85)
			return coord_t'($urandom_range(33554432)) - 32'sd16777216;
		case ($urandom_range(4))
			0: return MAXV;
			1: return MINV;
			2: return 32'sd0;
			3: return 32'sd1;
			default: return -32'sd1;
		endcase
	endfunction

	initial begin : stimulus
		real    q[4];
		real    len, gain;
		coord_t qc[4];
		logic [CFG_W-1:0] tol;
		int     kind, n, n_vec;

		board = new();
		vec_in.valid  = 1'b0;
		vec_in.vec_x  = '0;
		vec_in.vec_y  = '0;
		vec_in.vec_z  = '0;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// --- directed part ---
		// identity after reset: exact pass-through, extremes of every field
		send_vec(32'sd0, 32'sd0, 32'sd0);
		send_vec(MAXV, MAXV, MAXV);
		send_vec(MINV, MINV, MINV);
		send_vec(MAXV, MINV, 32'sd1);
		send_vec(-32'sd1, 32'sd0, 32'sd65536);
		send_vec(32'sd65536, 32'sd131072, -32'sd196608);

		// quarter turn about z, with a write to an unused index first
		load_quat(ROOT_HALF, '0, '0, ROOT_HALF, TOL_DFLT, 1'b1);
		send_vec(32'sd65536, 32'sd0, 32'sd0);
		send_vec(32'sd0, 32'sd65536, 32'sd0);
		send_vec(MAXV, MINV, 32'sd0);
		send_vec(MINV, MINV, MINV);

		// w = -2.0: norm^2 = 4, not unit even at the widest tolerance
		load_quat(MINV, '0, '0, '0, TOL_MAX, 1'b0);
		send_vec(32'sd1, 32'sd2, 32'sd3);
		send_vec(MAXV, MINV, -32'sd1);

		// norm^2 just under 2 at the widest tolerance: scales by ~2, saturates
		load_quat(ROOT_TWO, '0, '0, '0, TOL_MAX, 1'b0);
		send_vec(MAXV, MINV, 32'sd0);
		send_vec(32'sd65536, -32'sd65536, 32'sh40000000);
		send_vec(-32'sh40000000, 32'sh3fffffff, 32'sd12345);

		// zero tolerance, exact identity still counts as unit
		load_quat(QUAT_ONE, '0, '0, '0, '0, 1'b0);
		send_vec(32'sd12345, -32'sd12345, MINV);

		// tolerance edge at 21 LSBs: w off by 10 passes, off by 11 fails
		load_quat(QUAT_ONE + 32'sd10, '0, '0, '0, TOL_DFLT, 1'b0);
		send_vec(MAXV, 32'sd1, 32'sd2);
		load_quat(QUAT_ONE + 32'sd11, '0, '0, '0, TOL_DFLT, 1'b0);
		send_vec(MAXV, 32'sd1, 32'sd2);

		// --- random part: one quaternion per phase, a burst of vectors each ---
		while (sent < N_ITEMS) begin
			kind = $urandom_range(99);
			if (kind < 65) begin
				// random direction normalized to unit length
				do begin
					for (n = 0; n < 4; n++)
						q[n] = real'($urandom_range(2000000)) / 1000000.0 - 1.0;
					len = $sqrt(q[0]*q[0] + q[1]*q[1] + q[2]*q[2] + q[3]*q[3]);
				end while (len < 0.1);
				gain = real'(QUAT_ONE) / len;
				if (kind >= 50) begin
					// norm^2 anywhere in 0.5..1.99, accepted by the widest tolerance
					gain = gain * $sqrt(0.5 + real'($urandom_range(1490)) / 1000.0);
					tol = TOL_MAX;
				end else begin
					tol = $urandom_range(1) ? TOL_DFLT : $urandom_range(1000);
				end
				for (n = 0; n < 4; n++)
					qc[n] = $rtoi(q[n] * gain);
			end else if (kind < 80) begin
				// one axis at +-1.0 give or take a few LSBs, near the tolerance edge
				for (n = 0; n < 4; n++)
					qc[n] = '0;
				n = $urandom_range(3);
				qc[n] = QUAT_ONE + coord_t'($urandom_range(24)) - 32'sd12;
				if ($urandom_range(1))
					qc[n] = -qc[n];
				tol = $urandom_range(1) ? TOL_DFLT : $urandom_range(30);
			end else begin
				// raw bits everywhere; upper tolerance bits must be dropped
				for (n = 0; n < 4; n++)
					qc[n] = $urandom();
				tol = $urandom();
			end
			load_quat(qc[0], qc[1], qc[2], qc[3], tol, $urandom_range(3) == 0);

			src_idle_pct = 20 * $urandom_range(3);
			snk_idle_pct = 20 * $urandom_range(3);
			n_vec = $urandom_range(80, 20);
			repeat (n_vec) send_vec(pick_coord(), pick_coord(), pick_coord());
		end
		vec_in.valid <= 1'b0;

		while (board.rotations_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (board.mismatches == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

endmodule

// ===== filelist.f =====
hw/rtl/qvr_pkg.sv
hw/rtl/qvr_if.sv
hw/rtl/qvr_coef.sv
hw/rtl/quaternion_vector_rotate.sv
test/qvr_tb_pkg.sv
test/tb.sv
